// ===== hw/rtl/address_pattern_match_defines.svh =====
`ifndef ADDRESS_PATTERN_MATCH_DEFINES_SVH
`define ADDRESS_PATTERN_MATCH_DEFINES_SVH
// Assertion macros. Each expects clk and rst_n in the scope of its use.
`ifndef NO_ASSERTIONS
`define APM_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define APM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APM_ASSERT_IMM(label, ante, cons, msg)
`define APM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/apm_pkg.sv =====
package apm_pkg;

  typedef logic [7:0] char_t;

  // Pattern syntax characters.
  localparam char_t CH_QUESTION = 8'h3F;
  localparam char_t CH_STAR     = 8'h2A;
  localparam char_t CH_LBRACKET = 8'h5B;
  localparam char_t CH_BANG     = 8'h21;
  localparam char_t CH_DASH     = 8'h2D;
  localparam char_t CH_RBRACKET = 8'h5D;
  localparam char_t CH_LBRACE   = 8'h7B;
  localparam char_t CH_COMMA    = 8'h2C;
  localparam char_t CH_RBRACE   = 8'h7D;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_STEP,
    S_STAR,
    S_SET_BANG,
    S_SET_FIRST,
    S_SET_SECOND,
    S_SET_LIST,
    S_RANGE_HI,
    S_RANGE_END,
    S_ALT,
    S_ALT_SKIP
  } apm_state_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_INC,
    I_START
  } apm_iop_t;

  typedef struct packed {
    logic     load;
    apm_iop_t i_op;
    logic     j_inc;
    logic     save_start;
    logic     save_lo;
    logic     save_hi;
    logic     set_clr;
    logic     set_neg;
    logic     hit_lo;
    logic     hit_p;
    logic     ok_set;
    logic     ok_clr;
    logic     res_push;
    logic     res_match;
    logic     res_ovf;
  } apm_cmd_t;

  typedef struct packed {
    logic p_is_q;
    logic p_is_star;
    logic p_is_lbr;
    logic p_is_bang;
    logic p_is_dash;
    logic p_is_rbr;
    logic p_is_lbrace;
    logic p_is_comma;
    logic p_is_rbrace;
    logic a_eq_p;
    logic lo_is_rbr;
    logic range_hit;
    logic i_lt_na;
    logic i_eq_na;
    logic j_lt_np;
    logic j_eq_np;
    logic j1_lt_np;
    logic negate;
    logic hit;
    logic ok;
    logic ovf;
    logic out_free;
  } apm_status_t;

endpackage

// ===== hw/rtl/apm_in_if.sv =====
interface apm_in_if;
  import apm_pkg::*;

  logic  valid;
  logic  ready;
  char_t addr_char;
  logic  addr_valid;
  char_t pat_char;
  logic  pat_valid;
  logic  last;

  modport source (
    output valid, addr_char, addr_valid, pat_char, pat_valid, last,
    input  ready
  );

  modport sink (
    input  valid, addr_char, addr_valid, pat_char, pat_valid, last,
    output ready
  );
endinterface

// ===== hw/rtl/apm_out_if.sv =====
interface apm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (
    output valid, matched, overflow,
    input  ready
  );

  modport sink (
    input  valid, matched, overflow,
    output ready
  );
endinterface

// ===== hw/rtl/apm_datapath.sv =====
module apm_datapath #(
  parameter int MAX_ADDRESS_LEN = 64,
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apm_pkg::apm_cmd_t    cmd,
  output apm_pkg::apm_status_t stat,
  input  apm_pkg::char_t       addr_char,
  input  logic                 addr_valid,
  input  apm_pkg::char_t       pat_char,
  input  logic                 pat_valid,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 matched,
  output logic                 overflow
);
  import apm_pkg::*;

  localparam int AW  = $clog2(MAX_ADDRESS_LEN);
  localparam int PW  = $clog2(MAX_PATTERN_LEN);
  localparam int ALW = $clog2(MAX_ADDRESS_LEN + 1);
  localparam int PLW = $clog2(MAX_PATTERN_LEN + 1);

  char_t amem [MAX_ADDRESS_LEN];
  char_t pmem [MAX_PATTERN_LEN];

  logic [ALW-1:0] alen_r, i_r, i_nxt, start_r;
  logic [PLW-1:0] plen_r, j_r, j_nxt;
  logic [PLW:0]   j_plus1;
  char_t          a_rd_r, p_rd_r, lo_r, hi_r;
  logic           ovf_seen_r, negate_r, hit_r, ok_r;
  logic           out_valid_r, matched_r, overflow_r;
  logic           a_full, p_full;

  assign a_full = (alen_r == ALW'(MAX_ADDRESS_LEN));
  assign p_full = (plen_r == PLW'(MAX_PATTERN_LEN));

  // Walk pointers; the stores are read at the next pointer value so that the
  // registered read data lines up with the pointer registers.
  always_comb begin
    case (cmd.i_op)
      I_INC:   i_nxt = i_r + ALW'(1);
      I_START: i_nxt = start_r;
      default: i_nxt = i_r;
    endcase
    j_nxt = cmd.j_inc ? j_r + PLW'(1) : j_r;
    if (cmd.res_push) begin
      i_nxt = '0;
      j_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && addr_valid && !a_full) begin
      amem[alen_r[AW-1:0]] <= addr_char;
    end
    a_rd_r <= amem[i_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && pat_valid && !p_full) begin
      pmem[plen_r[PW-1:0]] <= pat_char;
    end
    p_rd_r <= pmem[j_nxt[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r      <= '0;
      plen_r      <= '0;
      ovf_seen_r  <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (cmd.load) begin
        if (addr_valid) begin
          if (a_full) ovf_seen_r <= 1'b1;
          else        alen_r     <= alen_r + ALW'(1);
        end
        if (pat_valid) begin
          if (p_full) ovf_seen_r <= 1'b1;
          else        plen_r     <= plen_r + PLW'(1);
        end
      end
      if (cmd.res_push) begin
        alen_r     <= '0;
        plen_r     <= '0;
        ovf_seen_r <= 1'b0;
      end
      if (cmd.res_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      matched_r  <= cmd.res_match;
      overflow_r <= cmd.res_ovf;
    end
    if (cmd.save_start) start_r <= i_r;
    if (cmd.save_lo)    lo_r    <= p_rd_r;
    if (cmd.save_hi)    hi_r    <= p_rd_r;
    if (cmd.set_clr) begin
      negate_r <= 1'b0;
      hit_r    <= 1'b0;
    end
    if (cmd.set_neg) negate_r <= 1'b1;
    if (cmd.hit_lo)  hit_r    <= hit_r | (a_rd_r == lo_r);
    if (cmd.hit_p)   hit_r    <= hit_r | (a_rd_r == p_rd_r);
    if (cmd.ok_set)  ok_r     <= 1'b1;
    if (cmd.ok_clr)  ok_r     <= 1'b0;
  end

  assign j_plus1 = {1'b0, j_r} + (PLW + 1)'(1);

  always_comb begin
    stat.p_is_q      = (p_rd_r == CH_QUESTION);
    stat.p_is_star   = (p_rd_r == CH_STAR);
    stat.p_is_lbr    = (p_rd_r == CH_LBRACKET);
    stat.p_is_bang   = (p_rd_r == CH_BANG);
    stat.p_is_dash   = (p_rd_r == CH_DASH);
    stat.p_is_rbr    = (p_rd_r == CH_RBRACKET);
    stat.p_is_lbrace = (p_rd_r == CH_LBRACE);
    stat.p_is_comma  = (p_rd_r == CH_COMMA);
    stat.p_is_rbrace = (p_rd_r == CH_RBRACE);
    stat.a_eq_p      = (a_rd_r == p_rd_r);
    stat.lo_is_rbr   = (lo_r == CH_RBRACKET);
    // Reversed bounds are swapped before the range test.
    if (lo_r <= hi_r) stat.range_hit = (a_rd_r >= lo_r) && (a_rd_r <= hi_r);
    else              stat.range_hit = (a_rd_r >= hi_r) && (a_rd_r <= lo_r);
    stat.i_lt_na  = (i_r < alen_r);
    stat.i_eq_na  = (i_r == alen_r);
    stat.j_lt_np  = (j_r < plen_r);
    stat.j_eq_np  = (j_r == plen_r);
    stat.j1_lt_np = (j_plus1 < {1'b0, plen_r});
    stat.negate   = negate_r;
    stat.hit      = hit_r;
    stat.ok       = ok_r;
    stat.ovf      = ovf_seen_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign matched   = matched_r;
  assign overflow  = overflow_r;
endmodule

// ===== hw/rtl/apm_ctrl.sv =====
module apm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  apm_pkg::apm_status_t stat,
  output logic                 in_ready,
  output apm_pkg::apm_cmd_t    cmd
);
  import apm_pkg::*;

  apm_state_t state_r, state_nxt, fin_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A finishing state holds until the output register can take the result.
  assign fin_state = stat.out_free ? S_LOAD : state_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_last) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = stat.ovf ? fin_state : S_STEP;
      end
      S_STEP: begin
        if (!(stat.i_lt_na && stat.j_lt_np)) state_nxt = fin_state;
        else if (stat.p_is_q)                state_nxt = S_STEP;
        else if (stat.p_is_star)             state_nxt = S_STAR;
        else if (stat.p_is_lbr)              state_nxt = S_SET_BANG;
        else if (stat.p_is_lbrace)           state_nxt = S_ALT;
        else if (!stat.a_eq_p)               state_nxt = fin_state;
      end
      S_STAR: begin
        if (!stat.j_lt_np || !stat.i_lt_na) state_nxt = fin_state;
        else if (stat.a_eq_p)               state_nxt = S_STEP;
      end
      S_SET_BANG: state_nxt = S_SET_FIRST;
      S_SET_FIRST: begin
        state_nxt = stat.j_lt_np ? S_SET_SECOND : fin_state;
      end
      S_SET_SECOND: begin
        if (stat.j_lt_np && stat.p_is_dash) state_nxt = S_RANGE_HI;
        else if (stat.lo_is_rbr)            state_nxt = stat.negate ? S_STEP : fin_state;
        else                                state_nxt = S_SET_LIST;
      end
      S_SET_LIST: begin
        if (!stat.j_lt_np) state_nxt = fin_state;
        else if (stat.p_is_rbr) begin
          state_nxt = (stat.hit == stat.negate) ? fin_state : S_STEP;
        end
      end
      S_RANGE_HI: begin
        state_nxt = stat.j1_lt_np ? S_RANGE_END : fin_state;
      end
      S_RANGE_END: begin
        if (!stat.p_is_rbr || (stat.range_hit == stat.negate)) state_nxt = fin_state;
        else                                                    state_nxt = S_STEP;
      end
      S_ALT: begin
        if (!stat.j_lt_np) state_nxt = fin_state;
        else if (stat.p_is_comma || stat.p_is_rbrace) begin
          if (stat.ok)               state_nxt = S_ALT_SKIP;
          else if (stat.p_is_rbrace) state_nxt = fin_state;
        end
      end
      S_ALT_SKIP: begin
        if (!stat.j_lt_np)       state_nxt = fin_state;
        else if (stat.p_is_rbrace) state_nxt = S_STEP;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    logic fin;
    logic fin_match;
    fin       = 1'b0;
    fin_match = 1'b0;
    cmd       = '0;
    cmd.i_op  = I_HOLD;
    in_ready  = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        fin = stat.ovf;
      end
      S_STEP: begin
        if (!(stat.i_lt_na && stat.j_lt_np)) begin
          fin       = 1'b1;
          fin_match = stat.i_eq_na && stat.j_eq_np;
        end else if (stat.p_is_q) begin
          cmd.i_op  = I_INC;
          cmd.j_inc = 1'b1;
        end else if (stat.p_is_star) begin
          cmd.j_inc = 1'b1;
        end else if (stat.p_is_lbr) begin
          cmd.j_inc   = 1'b1;
          cmd.set_clr = 1'b1;
        end else if (stat.p_is_lbrace) begin
          cmd.save_start = 1'b1;
          cmd.j_inc      = 1'b1;
          cmd.ok_set     = 1'b1;
        end else if (stat.a_eq_p) begin
          cmd.i_op  = I_INC;
          cmd.j_inc = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      S_STAR: begin
        if (!stat.j_lt_np) begin
          fin       = 1'b1;
          fin_match = 1'b1;
        end else if (!stat.i_lt_na) begin
          fin = 1'b1;
        end else begin
          cmd.i_op  = I_INC;
          cmd.j_inc = stat.a_eq_p;
        end
      end
      S_SET_BANG: begin
        if (stat.j_lt_np && stat.p_is_bang) begin
          cmd.set_neg = 1'b1;
          cmd.j_inc   = 1'b1;
        end
      end
      S_SET_FIRST: begin
        if (!stat.j_lt_np) begin
          fin = 1'b1;
        end else begin
          cmd.save_lo = 1'b1;
          cmd.j_inc   = 1'b1;
        end
      end
      S_SET_SECOND: begin
        if (stat.j_lt_np && stat.p_is_dash) begin
          cmd.j_inc = 1'b1;
        end else if (stat.lo_is_rbr) begin
          // Empty set: only a negated one passes.
          if (stat.negate) cmd.i_op = I_INC;
          else             fin      = 1'b1;
        end else begin
          cmd.hit_lo = 1'b1;
        end
      end
      S_SET_LIST: begin
        if (!stat.j_lt_np) begin
          fin = 1'b1;
        end else if (stat.p_is_rbr) begin
          if (stat.hit == stat.negate) begin
            fin = 1'b1;
          end else begin
            cmd.i_op  = I_INC;
            cmd.j_inc = 1'b1;
          end
        end else begin
          cmd.hit_p = 1'b1;
          cmd.j_inc = 1'b1;
        end
      end
      S_RANGE_HI: begin
        if (!stat.j1_lt_np) begin
          fin = 1'b1;
        end else begin
          cmd.save_hi = 1'b1;
          cmd.j_inc   = 1'b1;
        end
      end
      S_RANGE_END: begin
        if (!stat.p_is_rbr || (stat.range_hit == stat.negate)) begin
          fin = 1'b1;
        end else begin
          cmd.i_op  = I_INC;
          cmd.j_inc = 1'b1;
        end
      end
      S_ALT: begin
        if (!stat.j_lt_np) begin
          fin = 1'b1;
        end else if (stat.p_is_comma || stat.p_is_rbrace) begin
          if (!stat.ok) begin
            if (stat.p_is_rbrace) begin
              fin = 1'b1;
            end else begin
              // Next alternative starts again from the saved address position.
              cmd.j_inc  = 1'b1;
              cmd.i_op   = I_START;
              cmd.ok_set = 1'b1;
            end
          end
        end else begin
          cmd.j_inc = 1'b1;
          if (stat.ok && stat.i_lt_na && stat.a_eq_p) cmd.i_op   = I_INC;
          else                                        cmd.ok_clr = 1'b1;
        end
      end
      S_ALT_SKIP: begin
        if (!stat.j_lt_np) fin       = 1'b1;
        else               cmd.j_inc = 1'b1;
      end
      default: begin
        cmd.i_op = I_HOLD;
      end
    endcase
    if (fin && stat.out_free) begin
      cmd.res_push  = 1'b1;
      cmd.res_ovf   = stat.ovf;
      cmd.res_match = fin_match && !stat.ovf;
      cmd.i_op      = I_HOLD;
      cmd.j_inc     = 1'b0;
    end
  end
endmodule

// ===== hw/rtl/address_pattern_match.sv =====
// Channel   Direction  Payload                                         Transfer when
// in_if     sink       addr_char, addr_valid, pat_char, pat_valid, last valid && ready
// out_if    source     matched, overflow                               valid && ready
//
// While loading, one input transfer is taken per cycle. After the transfer marked last, a
// settling state checks for overflow; an overflow goes straight to the write of the result,
// else the match walk follows and ends with the write of the result.
// Reset (rst_n, synchronous, active low) empties both stores and the result register.
// A stalled result holds in the output register; loading of the next strings carries on,
// and only the end of the next match waits for the register to drain.
`include "address_pattern_match_defines.svh"

module address_pattern_match #(
  parameter int MAX_ADDRESS_LEN = 64,
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  apm_in_if.sink    in_if,
  apm_out_if.source out_if
);
  import apm_pkg::*;

  apm_cmd_t    cmd;
  apm_status_t stat;

  // The controller sequences the match walk; it sees only decoded flags from the
  // datapath and never the characters themselves.
  apm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last),
    .stat     (stat),
    .in_ready (in_if.ready),
    .cmd      (cmd)
  );

  // The datapath holds both stores, their lengths, the walk pointers, the set and
  // alternative flags, and the output register.
  apm_datapath #(
    .MAX_ADDRESS_LEN (MAX_ADDRESS_LEN),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .addr_char  (in_if.addr_char),
    .addr_valid (in_if.addr_valid),
    .pat_char   (in_if.pat_char),
    .pat_valid  (in_if.pat_valid),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .matched    (out_if.matched),
    .overflow   (out_if.overflow)
  );

  // A result is only ever written into a free output register.
  `APM_ASSERT_IMM(a_push_into_free, cmd.res_push, stat.out_free, "result pushed over a pending one")
  // An overflowed string pair never reports a match.
  `APM_ASSERT_IMM(a_ovf_no_match, cmd.res_push && cmd.res_ovf, !cmd.res_match, "match with overflow")
  // After a result the block is back to loading with the result on offer.
  `APM_ASSERT_NXT(a_push_reload, cmd.res_push, in_if.ready && out_if.valid, "no return to loading")
endmodule

// ===== bench/match_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the address pattern matcher. It keeps its own copy of the
// two character stores, works out the result of every string pair when its last
// transfer is seen, and compares each result transfer with the oldest prediction.
module match_result_checker #(
  parameter int ADDR_DEPTH = 64,
  parameter int PAT_DEPTH  = 64
) (
  input  logic clk,
  input  logic rst_n,
  apm_in_if    in_mon,
  apm_out_if   out_mon,
  output int   pending,
  output int   errors
);
  import apm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_result_t;

  char_t         addr_chars [ADDR_DEPTH];
  char_t         pat_chars  [PAT_DEPTH];
  int            addr_len;
  int            pat_len;
  logic          overflow_seen;
  int            mismatches;
  match_result_t match_results_q [$];

  initial begin
    mismatches = 0;
  end

  // Walks the stored address against the stored pattern. The star stops at its first match,
  // never backtracks, and each brace alternative is tried from the same start.
  function automatic logic pattern_matches();
    int    i, j, na, np, start, cur, k;
    logic  negate, hit, ok, found;
    char_t pc, lo, hi, swap;
    na = addr_len;
    np = pat_len;
    i  = 0;
    j  = 0;
    while (i < na && j < np) begin
      pc = pat_chars[j];
      if (pc == CH_QUESTION) begin
      end else if (pc == CH_STAR) begin
        j++;
        if (j >= np) return 1'b1;
        while (i < na && addr_chars[i] != pat_chars[j]) i++;
        if (i >= na) return 1'b0;
      end else if (pc == CH_LBRACKET) begin
        negate = 1'b0;
        hit    = 1'b0;
        j++;
        if (j < np && pat_chars[j] == CH_BANG) begin
          negate = 1'b1;
          j++;
        end
        if (j >= np) return 1'b0;
        if (j + 1 < np && pat_chars[j + 1] == CH_DASH) begin
          if (j + 3 >= np || pat_chars[j + 3] != CH_RBRACKET) return 1'b0;
          lo = pat_chars[j];
          hi = pat_chars[j + 2];
          if (lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
          hit = (addr_chars[i] >= lo) && (addr_chars[i] <= hi);
          j += 3;
        end else begin
          while (j < np && pat_chars[j] != CH_RBRACKET) begin
            if (addr_chars[i] == pat_chars[j]) hit = 1'b1;
            j++;
          end
          if (j >= np) return 1'b0;
        end
        if (hit == negate) return 1'b0;
      end else if (pc == CH_LBRACE) begin
        start = i;
        cur   = i;
        k     = j + 1;
        found = 1'b0;
        while (!found) begin
          ok  = 1'b1;
          cur = start;
          while (k < np && pat_chars[k] != CH_COMMA && pat_chars[k] != CH_RBRACE) begin
            if (ok && cur < na && addr_chars[cur] == pat_chars[k]) cur++;
            else ok = 1'b0;
            k++;
          end
          if (k >= np) return 1'b0;
          if (ok) found = 1'b1;
          else if (pat_chars[k] == CH_RBRACE) return 1'b0;
          else k++;
        end
        while (k < np && pat_chars[k] != CH_RBRACE) k++;
        if (k >= np) return 1'b0;
        i = cur;
        j = k + 1;
        continue;
      end else if (addr_chars[i] != pc) begin
        return 1'b0;
      end
      i++;
      j++;
    end
    return (i == na) && (j == np);
  endfunction

  always @(posedge clk) begin
    match_result_t want;
    if (!rst_n) begin
      addr_len      = 0;
      pat_len       = 0;
      overflow_seen = 1'b0;
      match_results_q.delete();
    end else begin
      // Results first: a result can never belong to a last transfer at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (match_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, got matched %0b overflow %0b",
                   $time, out_mon.matched, out_mon.overflow);
        end else begin
          want = match_results_q.pop_front();
          if (out_mon.matched !== want.matched) begin
            mismatches++;
            $display("%0t: matched expected %0b, got %0b", $time, want.matched,
                     out_mon.matched);
          end
          if (out_mon.overflow !== want.overflow) begin
            mismatches++;
            $display("%0t: overflow expected %0b, got %0b", $time, want.overflow,
                     out_mon.overflow);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.addr_valid) begin
          if (addr_len < ADDR_DEPTH) begin
            addr_chars[addr_len] = in_mon.addr_char;
            addr_len++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        if (in_mon.pat_valid) begin
          if (pat_len < PAT_DEPTH) begin
            pat_chars[pat_len] = in_mon.pat_char;
            pat_len++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        if (in_mon.last) begin
          want.overflow = overflow_seen;
          want.matched  = overflow_seen ? 1'b0 : pattern_matches();
          match_results_q.insert(match_results_q.size(), want);
          addr_len      = 0;
          pat_len       = 0;
          overflow_seen = 1'b0;
        end
      end
    end
    pending <= match_results_q.size();
    errors  <= mismatches;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Top of the bench for the address pattern matcher. It makes the stimulus, drives the
// ready of the result channel and gives the verdict; all prediction and comparison is
// done by the result checker that sits beside the block.
module tb;
  import apm_pkg::*;

  localparam int ADDR_DEPTH   = 64;
  localparam int PAT_DEPTH    = 64;
  // A result walks both stores and may re-walk the address once per brace alternative,
  // so the settling time at the end is sized well above one full walk.
  localparam int DRAIN_CYCLES = 400;
  // The slowest run sends about 700 transfers, with long gaps in one phase, and waits out
  // long stalls on the results in another; the limit is many times that.
  localparam int CYCLE_LIMIT  = 400000;

  localparam char_t SYNTAX_CHARS [9] = '{CH_QUESTION, CH_STAR, CH_LBRACKET, CH_BANG,
                                         CH_DASH, CH_RBRACKET, CH_LBRACE, CH_COMMA,
                                         CH_RBRACE};

  logic  clk;
  logic  rst_n;
  int    cycles = 0;
  int    items_sent = 0;
  int    send_idle_pct = 11;
  int    recv_idle_pct = 88;
  int    pending;
  int    errors;
  char_t addr_str [$];
  char_t pat_str [$];

  apm_in_if  in_ch ();
  apm_out_if out_ch ();

  address_pattern_match #(
    .MAX_ADDRESS_LEN(ADDR_DEPTH),
    .MAX_PATTERN_LEN(PAT_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  match_result_checker #(
    .ADDR_DEPTH(ADDR_DEPTH),
    .PAT_DEPTH (PAT_DEPTH)
  ) i_result_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_mon (in_ch),
    .out_mon(out_ch),
    .pending(pending),
    .errors (errors)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls at random, at a rate that each phase of the run sets.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Appends one character to the address or the pattern being built.
  function automatic void addr_append(input char_t c);
    addr_str.insert(addr_str.size(), c);
  endfunction

  function automatic void pat_append(input char_t c);
    pat_str.insert(pat_str.size(), c);
  endfunction

  // Mostly a handful of letters, so that sets, stars and alternatives find their
  // characters often; now and then any byte that has no meaning in a pattern.
  function automatic char_t letter();
    char_t c;
    if ($urandom_range(3) != 0) return char_t'(8'h61 + $urandom_range(4));
    do c = char_t'($urandom_range(255));
    while (c inside {CH_QUESTION, CH_STAR, CH_LBRACKET, CH_BANG, CH_DASH, CH_RBRACKET,
                     CH_LBRACE, CH_COMMA, CH_RBRACE});
    return c;
  endfunction

  function automatic char_t syntax_char();
    return SYNTAX_CHARS[$urandom_range(8)];
  endfunction

  function automatic void load_strings(input string a, input string p);
    addr_str.delete();
    pat_str.delete();
    for (int k = 0; k < a.len(); k++) addr_append(char_t'(a[k]));
    for (int k = 0; k < p.len(); k++) pat_append(char_t'(p[k]));
  endfunction

  // Builds one string pair. Most pairs are patterns made of well-formed elements with an
  // address written to fit them, some of them then spoilt by one edit; the rest are
  // strings of random letters, bytes and syntax characters, and strings sized around the store depth.
  function automatic void make_random_pair();
    int    kind, n, n_alt, pick, idx;
    logic  negate, hit;
    char_t c, lo, hi;
    char_t members [$];
    addr_str.delete();
    pat_str.delete();
    kind = $urandom_range(99);
    if (kind < 4) begin
      // Store boundary: a full store is fine, one character more sets the overflow.
      n = $urandom_range(ADDR_DEPTH - 2, ADDR_DEPTH + 4);
      repeat (n) addr_append(letter());
      if ($urandom_range(1) == 0) pat_append(CH_STAR);
      else repeat (n) pat_append(CH_QUESTION);
    end else if (kind < 14) begin
      repeat ($urandom_range(8)) begin
        case ($urandom_range(2))
          0:       addr_append(syntax_char());
          1:       addr_append(letter());
          default: addr_append(char_t'($urandom_range(255)));
        endcase
      end
      repeat ($urandom_range(8)) begin
        case ($urandom_range(2))
          0:       pat_append(syntax_char());
          1:       pat_append(letter());
          default: pat_append(char_t'($urandom_range(255)));
        endcase
      end
    end else begin
      for (int t = $urandom_range(6); t > 0; t--) begin
        case ($urandom_range(6))
          0, 1: begin
            c = letter();
            pat_append(c);
            addr_append(c);
          end
          2: begin
            pat_append(CH_QUESTION);
            addr_append(char_t'($urandom_range(255)));
          end
          3: begin
            pat_append(CH_STAR);
            if ($urandom_range(4) == 0) begin
              // A star that ends the pattern swallows whatever address is left.
              repeat ($urandom_range(3)) addr_append(letter());
              break;
            end
            // The character after a star is taken literally, even a syntax character.
            c = ($urandom_range(3) == 0) ? syntax_char() : letter();
            pat_append(c);
            repeat ($urandom_range(3)) begin
              do lo = letter();
              while (lo == c);
              addr_append(lo);
            end
            addr_append(c);
          end
          4: begin
            negate = 1'($urandom_range(1));
            members.delete();
            repeat ($urandom_range(3)) members.insert(members.size(), letter());
            pat_append(CH_LBRACKET);
            if (negate) pat_append(CH_BANG);
            foreach (members[m]) pat_append(members[m]);
            pat_append(CH_RBRACKET);
            if (!negate && members.size() > 0) begin
              addr_append(members[$urandom_range(members.size() - 1)]);
            end else begin
              do begin
                c   = letter();
                hit = 1'b0;
                foreach (members[m]) if (members[m] == c) hit = 1'b1;
              end while (hit);
              addr_append(c);
            end
          end
          5: begin
            negate = 1'($urandom_range(1));
            lo = ($urandom_range(1) == 0) ? char_t'($urandom_range(255)) : letter();
            hi = ($urandom_range(1) == 0) ? char_t'($urandom_range(255)) : letter();
            pat_append(CH_LBRACKET);
            if (negate) pat_append(CH_BANG);
            pat_append(lo);
            pat_append(CH_DASH);
            pat_append(hi);
            pat_append(CH_RBRACKET);
            if (lo > hi) begin
              c  = lo;
              lo = hi;
              hi = c;
            end
            if (!negate) begin
              c = char_t'(lo + $urandom_range(hi - lo));
            end else begin
              // Try a few times for a character outside the range; a full range has none.
              c = char_t'($urandom_range(255));
              for (int r = 0; r < 8 && c >= lo && c <= hi; r++) c = char_t'($urandom_range(255));
            end
            addr_append(c);
          end
          default: begin
            n_alt = $urandom_range(1, 3);
            pick  = $urandom_range(n_alt - 1);
            pat_append(CH_LBRACE);
            for (int a = 0; a < n_alt; a++) begin
              if (a > 0) pat_append(CH_COMMA);
              repeat ($urandom_range(2)) begin
                c = letter();
                pat_append(c);
                if (a == pick) addr_append(c);
              end
            end
            pat_append(CH_RBRACE);
          end
        endcase
      end
      // One edit in three spoils the pair: a wrong character, a lost pattern character
      // (which may leave a set or brace unclosed), a stray syntax character, or a longer
      // address.
      case ($urandom_range(11))
        0: if (addr_str.size() > 0) addr_str[$urandom_range(addr_str.size() - 1)] = letter();
        1: if (pat_str.size() > 0) pat_str.delete($urandom_range(pat_str.size() - 1));
        2: addr_append(letter());
        3: begin
          idx = $urandom_range(pat_str.size());
          pat_str.insert(idx, syntax_char());
        end
        default: ;
      endcase
    end
  endfunction

  // One transfer on the input channel. A gap, when one is drawn, drops valid before the
  // item; otherwise valid stays high from the previous transfer.
  task automatic drive_item(input logic a_v, input char_t a_c, input logic p_v,
                            input char_t p_c, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.addr_valid <= a_v;
    in_ch.addr_char  <= a_c;
    in_ch.pat_valid  <= p_v;
    in_ch.pat_char   <= p_c;
    in_ch.last       <= is_last;
    do @(posedge clk);
    while (!in_ch.ready);
    items_sent++;
  endtask

  // Sends the current pair. In dense mode every transfer carries a character of each
  // string while there is one left; otherwise the characters are spread at random over
  // the transfers, with empty transfers between them and now and then after them.
  task automatic send_strings(input logic dense);
    int   ai, pi;
    logic take_a, take_p, is_last;
    ai = 0;
    pi = 0;
    do begin
      take_a  = (ai < addr_str.size()) && (dense || $urandom_range(3) != 0);
      take_p  = (pi < pat_str.size()) && (dense || $urandom_range(3) != 0);
      is_last = (ai + int'(take_a) == addr_str.size()) &&
                (pi + int'(take_p) == pat_str.size()) &&
                (dense || $urandom_range(7) != 0);
      drive_item(take_a, take_a ? addr_str[ai] : char_t'($urandom_range(255)),
                 take_p, take_p ? pat_str[pi] : char_t'($urandom_range(255)), is_last);
      ai += int'(take_a);
      pi += int'(take_p);
    end while (!is_last);
  endtask

  task automatic send_random_pairs(input int items_goal);
    while (items_sent < items_goal) begin
      make_random_pair();
      send_strings(1'b0);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.addr_valid <= 1'b0;
    in_ch.addr_char  <= '0;
    in_ch.pat_valid  <= 1'b0;
    in_ch.pat_char   <= '0;
    in_ch.last       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs. Two empty strings match each other.
    load_strings("", "");
    send_strings(1'b1);
    // A star that ends the pattern matches the rest at once, here a top-value byte.
    load_strings("a\377", "a*");
    send_strings(1'b1);
    // The address runs out before the character after the star is found.
    load_strings("xy", "*z");
    send_strings(1'b1);
    // The character after the star is literal although it is a question mark.
    load_strings("q?", "*?");
    send_strings(1'b1);
    // A reversed range with a top-value bound is swapped before the compare.
    load_strings("m", "[\377-a]");
    send_strings(1'b1);
    // A negated set that no member matches lets the character through.
    load_strings("d", "[!ab]");
    send_strings(1'b1);
    // An empty set has no members, so it never matches.
    load_strings("a", "[]");
    send_strings(1'b1);
    // An empty brace takes no address character and the question mark then takes a zero byte.
    load_strings("a", "{}?");
    addr_str[0] = 8'h00;
    send_strings(1'b1);
    // A set left open at the end of the pattern is malformed.
    load_strings("a", "[a");
    send_strings(1'b1);

    // Three phases: a sender that is seldom idle with a receiver that mostly stalls, then the
    // reverse, then both sides at full speed.
    send_random_pairs(230);
    send_idle_pct = 88;
    recv_idle_pct = 11;
    send_random_pairs(460);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pairs(700);
    in_ch.valid <= 1'b0;

    // A clock edge is awaited first so that the checker has counted the last prediction before the wait begins.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
